### rtl/fap_pkg.sv
// Package for the polynomial atan2 core: fixed-point formats, Q.30 coefficients,
// the per-step Horner constants and the flag bundle that travels with each item.
// No dependencies.
package fap_pkg;

	// Ratio min/max carries this many fraction bits; the quotient needs one more bit.
	localparam int RATIO_BITS = 16;
	localparam int QUOT_WIDTH = RATIO_BITS + 1;
	localparam int DIV_STEPS  = QUOT_WIDTH;

	// Coefficients and the Horner terms are Q.30; the quotient carries RATIO_BITS fraction bits.
	localparam int COEF_BITS    = 30;
	localparam int LIN_SHIFT    = COEF_BITS - RATIO_BITS;
	localparam int T_WIDTH      = 32;
	localparam int PROD_WIDTH   = T_WIDTH + QUOT_WIDTH + 1;
	localparam int MAG_WIDTH    = 34;
	localparam int HORNER_STEPS = 9;

	// Fold, divider, Horner steps, sum, unfold, rounding.
	localparam int LATENCY = 1 + DIV_STEPS + HORNER_STEPS + 3;

	localparam logic signed [T_WIDTH-1:0] K_C1 = 32'sd35798849;
	localparam logic signed [T_WIDTH-1:0] K_C2 = 32'sd151316430;
	localparam logic signed [T_WIDTH-1:0] K_C3 = 32'sd205788697;
	localparam logic signed [T_WIDTH-1:0] K_C4 = 32'sd217886256;
	localparam logic signed [T_WIDTH-1:0] K_C5 = 32'sd358042018;

	localparam logic signed [MAG_WIDTH-1:0] K_PI      = 34'sd3373259426;
	localparam logic signed [MAG_WIDTH-1:0] K_HALF_PI = 34'sd1686629713;

	// Axis cases that bypass the polynomial.
	typedef enum logic [1:0] {
		SPC_NONE,
		SPC_ZERO,
		SPC_PI,
		SPC_HALF_PI
	} spc_t;

	typedef struct packed {
		spc_t spc;
		logic swap;   // |y| > |x|: unfold with pi/2 - r
		logic xneg;   // x < 0: unfold with pi - r
		logic neg;    // y < 0: negate the rounded magnitude
	} flags_t;

	// Constant added after the multiplication in each Horner step.
	function automatic logic signed [T_WIDTH-1:0] horner_add(input int unsigned step);
		logic signed [T_WIDTH-1:0] c;
		case (step)
			0:       c = K_C2;
			1:       c = -K_C3;
			3:       c = K_C4;
			5:       c = -K_C5;
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

### rtl/fast_atan2_polynomial_core.sv
// Four-quadrant fixed-point arctangent core: octant fold, pipelined restoring
// divider, pipelined Horner polynomial, unfold and rounding.
// Depends on fap_pkg.
//
// Channel   Signals                     Direction  Transfer
// command   start, busy, coord_x/y      in         start && !busy at rising edge
// result    done, angle                 out        done for one cycle, no back-pressure
//
// One transaction enters every cycle; each result passes through the whole pipeline
// (1 fold stage, 17 divider stages, 9 Horner multiplier stages, 3 stages for sum,
// unfold and rounding). The divider, one quotient bit per stage, sets the depth.
// busy stays low: the pipeline never stalls since the receiver cannot hold results
// off. arst_n clears the valid bits only; no transaction in flight survives reset.
module fast_atan2_polynomial_core #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [COORD_WIDTH-1:0]     coord_x,
	input  logic signed [COORD_WIDTH-1:0]     coord_y,
	output logic                              done,
	output logic signed [ANGLE_FRAC_BITS+2:0] angle
);
	import fap_pkg::*;

	localparam int ANGLE_WIDTH = ANGLE_FRAC_BITS + 3;
	localparam int RND_SHIFT   = COEF_BITS - ANGLE_FRAC_BITS;

	assign busy = 1'b0;

	// ---------------- fold stage ----------------
	logic [COORD_WIDTH-1:0] abs_x, abs_y;
	logic                   swap_c;
	flags_t                 flags_c;

	logic                   valid_s1;
	logic [COORD_WIDTH-1:0] lo_s1, hi_s1;
	flags_t                 flags_s1;

	always_comb begin
		abs_x  = coord_x[COORD_WIDTH-1] ? (~coord_x + 1'b1) : coord_x;
		abs_y  = coord_y[COORD_WIDTH-1] ? (~coord_y + 1'b1) : coord_y;
		swap_c = abs_y > abs_x;
		flags_c.swap = swap_c;
		flags_c.xneg = coord_x[COORD_WIDTH-1];
		flags_c.neg  = coord_y[COORD_WIDTH-1];
		if (coord_y == '0) begin
			flags_c.spc = coord_x[COORD_WIDTH-1] ? SPC_PI : SPC_ZERO;
		end else if (coord_x == '0) begin
			flags_c.spc = SPC_HALF_PI;
		end else begin
			flags_c.spc = SPC_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		lo_s1    <= swap_c ? abs_x : abs_y;
		hi_s1    <= swap_c ? abs_y : abs_x;
		flags_s1 <= flags_c;
	end

	// ---------------- divider: one quotient bit per stage ----------------
	logic                   div_valid_sd [DIV_STEPS];
	logic [COORD_WIDTH-1:0] div_rem_sd   [DIV_STEPS];
	logic [COORD_WIDTH-1:0] div_hi_sd    [DIV_STEPS];
	logic [QUOT_WIDTH-1:0]  div_quot_sd  [DIV_STEPS];
	flags_t                 div_flags_sd [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		logic [COORD_WIDTH:0]   trial;
		logic                   qbit;
		logic                   v_in;
		logic [COORD_WIDTH-1:0] hi_in;
		logic [QUOT_WIDTH-1:0]  q_in;
		flags_t                 fl_in;

		if (k == 0) begin : g_first
			// lo <= hi, so the leading quotient bit is set only when they are equal.
			assign trial = {1'b0, lo_s1};
			assign v_in  = valid_s1;
			assign hi_in = hi_s1;
			assign q_in  = '0;
			assign fl_in = flags_s1;
		end else begin : g_next
			assign trial = {div_rem_sd[k-1], 1'b0};
			assign v_in  = div_valid_sd[k-1];
			assign hi_in = div_hi_sd[k-1];
			assign q_in  = div_quot_sd[k-1];
			assign fl_in = div_flags_sd[k-1];
		end

		assign qbit = trial >= {1'b0, hi_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_sd[k] <= 1'b0;
			end else begin
				div_valid_sd[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			div_rem_sd[k]   <= qbit ? COORD_WIDTH'(trial - {1'b0, hi_in})
			                        : trial[COORD_WIDTH-1:0];
			div_hi_sd[k]    <= hi_in;
			div_quot_sd[k]  <= {q_in[QUOT_WIDTH-2:0], qbit};
			div_flags_sd[k] <= fl_in;
		end
	end

	// ---------------- Horner: one multiplication per stage ----------------
	logic                         hz_valid_sh [HORNER_STEPS];
	logic signed [T_WIDTH-1:0]    hz_t_sh     [HORNER_STEPS];
	logic [QUOT_WIDTH-1:0]        hz_a_sh     [HORNER_STEPS];
	flags_t                       hz_flags_sh [HORNER_STEPS];

	for (genvar j = 0; j < HORNER_STEPS; j++) begin : g_hz
		logic signed [T_WIDTH-1:0]    t_in;
		logic [QUOT_WIDTH-1:0]        a_in;
		logic                         v_in;
		flags_t                       fl_in;
		logic signed [PROD_WIDTH-1:0] prod;

		if (j == 0) begin : g_first
			assign t_in  = -K_C1;
			assign a_in  = div_quot_sd[DIV_STEPS-1];
			assign v_in  = div_valid_sd[DIV_STEPS-1];
			assign fl_in = div_flags_sd[DIV_STEPS-1];
		end else begin : g_next
			assign t_in  = hz_t_sh[j-1];
			assign a_in  = hz_a_sh[j-1];
			assign v_in  = hz_valid_sh[j-1];
			assign fl_in = hz_flags_sh[j-1];
		end

		assign prod = t_in * $signed({1'b0, a_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hz_valid_sh[j] <= 1'b0;
			end else begin
				hz_valid_sh[j] <= v_in;
			end
		end

		// The arithmetic shift rounds the product toward minus infinity.
		always_ff @(posedge clk) begin
			hz_t_sh[j]     <= T_WIDTH'(prod >>> RATIO_BITS) + horner_add(j);
			hz_a_sh[j]     <= a_in;
			hz_flags_sh[j] <= fl_in;
		end
	end

	// ---------------- linear term ----------------
	logic                        valid_sm;
	logic signed [MAG_WIDTH-1:0] mag_sm;
	flags_t                      flags_sm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sm <= 1'b0;
		end else begin
			valid_sm <= hz_valid_sh[HORNER_STEPS-1];
		end
	end

	always_ff @(posedge clk) begin
		mag_sm   <= MAG_WIDTH'(hz_t_sh[HORNER_STEPS-1])
		          + $signed(MAG_WIDTH'({hz_a_sh[HORNER_STEPS-1], {LIN_SHIFT{1'b0}}}));
		flags_sm <= hz_flags_sh[HORNER_STEPS-1];
	end

	// ---------------- unfold, axis cases, clamp ----------------
	logic signed [MAG_WIDTH-1:0] unf_oct, unf_half, unf_full;

	logic                        valid_su;
	logic [MAG_WIDTH-1:0]        mag_su;
	logic                        neg_su;

	always_comb begin
		unf_oct  = flags_sm.swap ? (K_HALF_PI - mag_sm) : mag_sm;
		unf_half = flags_sm.xneg ? (K_PI - unf_oct) : unf_oct;
		case (flags_sm.spc)
			SPC_ZERO:    unf_full = '0;
			SPC_PI:      unf_full = K_PI;
			SPC_HALF_PI: unf_full = K_HALF_PI;
			default:     unf_full = unf_half;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_su <= 1'b0;
		end else begin
			valid_su <= valid_sm;
		end
	end

	always_ff @(posedge clk) begin
		mag_su <= unf_full[MAG_WIDTH-1] ? '0 : unf_full;
		neg_su <= flags_sm.neg;
	end

	// ---------------- round to nearest, apply sign ----------------
	logic [MAG_WIDTH-1:0]   rnd_sum;
	logic [ANGLE_WIDTH-1:0] rnd_q;

	always_comb begin
		rnd_sum = mag_su + (MAG_WIDTH'(1) << (RND_SHIFT - 1));
		rnd_q   = ANGLE_WIDTH'(rnd_sum >> RND_SHIFT);
	end

	logic                          valid_so;
	logic signed [ANGLE_WIDTH-1:0] angle_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_so <= 1'b0;
		end else begin
			valid_so <= valid_su;
		end
	end

	always_ff @(posedge clk) begin
		angle_so <= neg_su ? $signed(-rnd_q) : $signed(rnd_q);
	end

	assign done  = valid_so;
	assign angle = angle_so;

endmodule

### rtl/fap_checker.sv
// Port-level checker for the atan2 core and the bind that attaches it.
// Depends on fap_pkg and on fast_atan2_polynomial_core.
module fap_checker #(
	parameter int COORD_WIDTH     = 16,
	parameter int ANGLE_FRAC_BITS = 13
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input logic signed [COORD_WIDTH-1:0]     coord_x,
	input logic signed [COORD_WIDTH-1:0]     coord_y,
	input logic                              done,
	input logic signed [ANGLE_FRAC_BITS+2:0] angle
);
	import fap_pkg::*;

	localparam int RND_SHIFT = COEF_BITS - ANGLE_FRAC_BITS;
	localparam logic signed [MAG_WIDTH-1:0] PI_Q =
		(K_PI + (MAG_WIDTH'(1) << (RND_SHIFT - 1))) >>> RND_SHIFT;

	// The pipeline never refuses a command.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every result traces back to an accepted transaction.
	a_done_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result without a matching command");

	// The rounded angle never leaves [-pi, pi].
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(angle) <= PI_Q && $signed(angle) >= -PI_Q))
		else $error("angle out of range");

	// A point on the non-negative x axis gives exactly zero.
	a_pos_x_axis: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(coord_y == '0 && !coord_x[COORD_WIDTH-1], LATENCY)) |->
		(angle == '0))
		else $error("nonzero angle on the positive x axis");

	// Points below the x axis never give a positive angle.
	a_lower_half: assert property (@(posedge clk) disable iff (!arst_n)
		(done && $past(coord_y[COORD_WIDTH-1], LATENCY)) |->
		(angle[ANGLE_FRAC_BITS+2] || angle == '0))
		else $error("positive angle for negative y");

endmodule

bind fast_atan2_polynomial_core fap_checker #(
	.COORD_WIDTH     (COORD_WIDTH),
	.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_fap_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.coord_x (coord_x),
	.coord_y (coord_y),
	.done    (done),
	.angle   (angle)
);
